### hdl/rsdf_pkg.sv
// ----------------------------------------------------------------------------
// rsdf_pkg
// Shared codes, widths and control types of the recent sequence duplicate
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsdf_pkg;

	localparam int SEQ_W = 32;
	localparam int OP_W  = 2;

	localparam logic [SEQ_W-1:0] SEQ_ONES = 32'hffff_ffff;

	localparam logic [OP_W-1:0] OP_CHECK   = 2'd0;
	localparam logic [OP_W-1:0] OP_RECORD  = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_last;
	} dp_stat_t;

endpackage

`default_nettype wire

### hdl/recent_sequence_duplicate_filter.sv
// ----------------------------------------------------------------------------
// recent_sequence_duplicate_filter
// Duplicate filter over a ring of recently recorded sequence numbers.
// ----------------------------------------------------------------------------
// Each request carries a sequence number and an op (check, check then record,
// restart). One request is in work at a time. Its result is set by the sweep
// that reads the ring memory one slot per cycle through its single read port
// to find a match and the new minimum; the next request is taken once the
// result has been committed. A finished result sits in an output register,
// so the next request is taken while it waits. No clearing pass is needed
// after reset: the ring slots carry valid bits and an unwritten slot reads
// as all ones.
`default_nettype none

module recent_sequence_duplicate_filter #(
	parameter int RING_DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire [rsdf_pkg::OP_W-1:0]  op,
	input  wire [rsdf_pkg::SEQ_W-1:0] seq,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic                      is_new,
	output logic                      recorded
);

	rsdf_pkg::dp_cmd_t  cmd;
	rsdf_pkg::dp_stat_t stat;

	rsdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	rsdf_dpath #(
		.RING_DEPTH (RING_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.op       (op),
		.seq      (seq),
		.is_new   (is_new),
		.recorded (recorded)
	);

endmodule

`default_nettype wire

### hdl/rsdf_dpath.sv
// ----------------------------------------------------------------------------
// rsdf_dpath
// Ring memory, window bounds and the match and minimum sweep over the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module rsdf_dpath #(
	parameter int RING_DEPTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  rsdf_pkg::dp_cmd_t            cmd,
	output rsdf_pkg::dp_stat_t           stat,
	input  wire [rsdf_pkg::OP_W-1:0]     op,
	input  wire [rsdf_pkg::SEQ_W-1:0]    seq,
	output logic                         is_new,
	output logic                         recorded
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [rsdf_pkg::SEQ_W-1:0] mem [RING_DEPTH];
	logic [RING_DEPTH-1:0]      vld_q;

	logic [rsdf_pkg::SEQ_W-1:0] highest_q;
	logic [rsdf_pkg::SEQ_W-1:0] lowest_q;
	logic [IDX_W-1:0]           ws_q;
	logic [IDX_W-1:0]           rd_addr_q;

	logic [rsdf_pkg::SEQ_W-1:0] seq_q;
	logic                       gt_q;
	logic                       lt_q;
	logic                       rec_q;
	logic                       restart_q;
	logic                       match_q;
	logic [rsdf_pkg::SEQ_W-1:0] min_q;

	logic                       chk_s1;
	logic [rsdf_pkg::SEQ_W-1:0] rd_data_s1;
	logic                       vld_s1;
	logic [IDX_W-1:0]           idx_s1;

	logic                       is_new_q;
	logic                       recorded_q;

	logic [rsdf_pkg::SEQ_W-1:0] slot_val;
	logic [rsdf_pkg::SEQ_W-1:0] cand;
	logic                       wr_en;
	logic [IDX_W-1:0]           wr_idx;
	logic [IDX_W-1:0]           ws_next;

	// unwritten slots read as all ones
	assign slot_val = vld_s1 ? rd_data_s1 : rsdf_pkg::SEQ_ONES;
	// the minimum is taken over the ring as it stands after the write
	assign cand     = (rec_q && idx_s1 == ws_q) ? seq_q : slot_val;
	assign ws_next  = (ws_q == LAST_IDX) ? '0 : ws_q + IDX_W'(1);
	assign wr_en    = cmd.commit && (rec_q || restart_q);
	assign wr_idx   = restart_q ? '0 : ws_q;

	assign stat.rd_last = (rd_addr_q == LAST_IDX);
	assign is_new       = is_new_q;
	assign recorded     = recorded_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
		if (wr_en) begin
			mem[wr_idx] <= seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			highest_q <= '0;
			lowest_q  <= '0;
			ws_q      <= '0;
			rd_addr_q <= '0;
			chk_s1    <= 1'b0;
		end else begin
			chk_s1 <= cmd.rd_en;
			if (cmd.load) begin
				rd_addr_q <= '0;
			end else if (cmd.rd_en) begin
				rd_addr_q <= stat.rd_last ? '0 : rd_addr_q + IDX_W'(1);
			end
			if (cmd.commit) begin
				if (restart_q) begin
					highest_q <= seq_q;
					lowest_q  <= '0;
					ws_q      <= IDX_W'(1);
					vld_q     <= RING_DEPTH'(1);
				end else if (rec_q) begin
					if (gt_q) begin
						highest_q <= seq_q;
					end
					lowest_q      <= min_q;
					ws_q          <= ws_next;
					vld_q[ws_q]   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q     <= seq;
			gt_q      <= seq > highest_q;
			lt_q      <= seq < lowest_q;
			rec_q     <= (op == rsdf_pkg::OP_RECORD) && !(seq < lowest_q);
			restart_q <= (op == rsdf_pkg::OP_RESTART);
			match_q   <= 1'b0;
			min_q     <= rsdf_pkg::SEQ_ONES;
		end else if (chk_s1) begin
			match_q <= match_q | (slot_val == seq_q);
			if (cand < min_q) begin
				min_q <= cand;
			end
		end
		if (cmd.rd_en) begin
			vld_s1 <= vld_q[rd_addr_q];
			idx_s1 <= rd_addr_q;
		end
		if (cmd.commit) begin
			is_new_q   <= gt_q | (!lt_q & !match_q);
			recorded_q <= rec_q | restart_q;
		end
	end

	// every kept number was recorded at or below the maximum
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		lowest_q <= highest_q)
		else $error("lowest kept above highest seen");

	a_restart_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && restart_q |=> vld_q == RING_DEPTH'(1) && ws_q == IDX_W'(1))
		else $error("restart left ring state wrong");

endmodule

`default_nettype wire

### hdl/rsdf_ctrl.sv
// ----------------------------------------------------------------------------
// rsdf_ctrl
// Sequencer for one request: capture, ring sweep, drain and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module rsdf_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output rsdf_pkg::dp_cmd_t   cmd,
	input  rsdf_pkg::dp_stat_t  stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.rd_en  = (state_q == ST_SWEEP);
	assign cmd.commit = (state_q == ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (stat.rd_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold the result until the output register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP && stat.rd_last |=> state_q == ST_DRAIN)
		else $error("sweep did not end on last slot");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready)
		else $error("second request taken during sweep");

	a_commit_sets_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

endmodule

`default_nettype wire

### dv/recent_sequence_duplicate_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recent_sequence_duplicate_filter_checker
// Watches the request and result channels of the duplicate filter. It keeps
// a copy of the ring, the highest and lowest kept numbers and the write slot,
// and works out the verdict for each accepted request. Each result is then
// compared in order, field by field, with the oldest verdict due.
// ----------------------------------------------------------------------------
module recent_sequence_duplicate_filter_checker #(
	parameter int RING_DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire                       in_ready,
	input  wire [rsdf_pkg::OP_W-1:0]  op,
	input  wire [rsdf_pkg::SEQ_W-1:0] seq,
	input  wire                       out_valid,
	input  wire                       out_ready,
	input  wire                       is_new,
	input  wire                       recorded,
	output int                        errors,
	output int                        outstanding
);

	typedef struct packed {
		logic is_new;
		logic recorded;
	} verdict_t;

	logic [rsdf_pkg::SEQ_W-1:0] ring_copy [RING_DEPTH];
	logic [rsdf_pkg::SEQ_W-1:0] top_seq;
	logic [rsdf_pkg::SEQ_W-1:0] floor_seq;
	int                         next_slot;
	verdict_t                   verdicts_due [$];
	verdict_t                   want;
	int                         fails;
	int                         results_seen;

	// verdict against the current state, then the state update the op asks for
	function automatic verdict_t judge_seq(input logic [rsdf_pkg::OP_W-1:0] o,
		input logic [rsdf_pkg::SEQ_W-1:0] s);
		verdict_t                   v;
		logic                       hit;
		logic [rsdf_pkg::SEQ_W-1:0] lo;
		int                         i;
		hit = 1'b0;
		for (i = 0; i < RING_DEPTH; i++)
			if (ring_copy[i] == s)
				hit = 1'b1;
		v.is_new = (s > top_seq) || (!(s < floor_seq) && !hit);
		v.recorded = 1'b0;
		case (o)
			rsdf_pkg::OP_RECORD: begin
				if (!(s < floor_seq)) begin
					if (s > top_seq)
						top_seq = s;
					ring_copy[next_slot] = s;
					next_slot = (next_slot + 1) % RING_DEPTH;
					lo = rsdf_pkg::SEQ_ONES;
					for (i = 0; i < RING_DEPTH; i++)
						if (ring_copy[i] < lo)
							lo = ring_copy[i];
					floor_seq = lo;
					v.recorded = 1'b1;
				end
			end
			rsdf_pkg::OP_RESTART: begin
				for (i = 0; i < RING_DEPTH; i++)
					ring_copy[i] = rsdf_pkg::SEQ_ONES;
				ring_copy[0] = s;
				top_seq = s;
				floor_seq = '0;
				next_slot = 1 % RING_DEPTH;
				v.recorded = 1'b1;
			end
			default: begin
				// check only, spare code included
			end
		endcase
		return v;
	endfunction

	task automatic note_mismatch(input string field, input logic exp_bit, input logic got_bit);
		fails++;
		$display("%0t: %s mismatch on result %0d: expected %0b, actual %0b",
			$time, field, results_seen, exp_bit, got_bit);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++)
				ring_copy[i] = rsdf_pkg::SEQ_ONES;
			top_seq = '0;
			floor_seq = '0;
			next_slot = 0;
			verdicts_due.delete();
			fails = 0;
			results_seen = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					fails++;
					$display("%0t: result with no request pending, %s is_new=%0b recorded=%0b",
						$time, "expected none, actual", is_new, recorded);
				end else begin
					want = verdicts_due.pop_front();
					if (is_new !== want.is_new)
						note_mismatch("is_new", want.is_new, is_new);
					if (recorded !== want.recorded)
						note_mismatch("recorded", want.recorded, recorded);
				end
				results_seen++;
			end
			if (in_valid && in_ready)
				verdicts_due.push_back(judge_seq(op, seq));
			errors <= fails;
			outstanding <= verdicts_due.size();
		end
	end

endmodule

### dv/recent_sequence_duplicate_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recent_sequence_duplicate_filter_tb
// Drives the duplicate filter with a short directed run over the corner
// cases and then with streams of sequence numbers that restart, advance,
// repeat and arrive late, mixed with random noise. Both sides idle at random
// and the result side holds off once long enough to back up the requests.
// ----------------------------------------------------------------------------
module recent_sequence_duplicate_filter_tb;

	localparam int                        RING_DEPTH  = 16;
	localparam int                        ITEM_TARGET = 850;
	localparam logic [rsdf_pkg::OP_W-1:0] OP_SPARE    = 2'd3;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic [rsdf_pkg::OP_W-1:0]  op;
	logic [rsdf_pkg::SEQ_W-1:0] seq;
	logic                       out_ready;
	wire                        in_ready;
	wire                        out_valid;
	wire                        is_new;
	wire                        recorded;
	int                         errors;
	int                         outstanding;

	logic                       calm;
	logic                       squeeze_now;
	int                         sent;
	logic [rsdf_pkg::SEQ_W-1:0] head;

	always #5 clk = ~clk;

	recent_sequence_duplicate_filter #(
		.RING_DEPTH(RING_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.seq(seq),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_new(is_new),
		.recorded(recorded)
	);

	recent_sequence_duplicate_filter_checker #(
		.RING_DEPTH(RING_DEPTH)
	) shadow (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.seq(seq),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_new(is_new),
		.recorded(recorded),
		.errors(errors),
		.outstanding(outstanding)
	);

	// mostly no gap, some short, a few long; none while calm
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// called right after an edge; returns at the edge the request is taken
	task automatic send_request(input logic [rsdf_pkg::OP_W-1:0] o,
		input logic [rsdf_pkg::SEQ_W-1:0] s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		seq <= s;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// one stream from a restart: in order, jumps, late and repeated numbers,
	// checks around the head, and some noise
	task automatic run_stream();
		int                         len;
		int                         pick;
		logic [rsdf_pkg::OP_W-1:0]  o;
		logic [rsdf_pkg::SEQ_W-1:0] s;
		case ($urandom_range(0, 3))
			0: head = $urandom_range(0, 50);
			1: head = rsdf_pkg::SEQ_ONES - $urandom_range(0, 60);
			default: head = $urandom();
		endcase
		calm = ($urandom_range(0, 5) == 0);
		send_request(rsdf_pkg::OP_RESTART, head);
		len = $urandom_range(15, 60);
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				head = head + 1;
				o = rsdf_pkg::OP_RECORD;
				s = head;
			end else if (pick < 50) begin
				head = head + $urandom_range(2, 6);
				o = rsdf_pkg::OP_RECORD;
				s = head;
			end else if (pick < 62) begin
				o = rsdf_pkg::OP_RECORD;
				s = head - $urandom_range(0, 24);
			end else if (pick < 80) begin
				o = rsdf_pkg::OP_CHECK;
				s = head + 2 - $urandom_range(0, 30);
			end else if (pick < 85) begin
				o = OP_SPARE;
				s = head - $urandom_range(0, 20);
			end else if (pick < 88) begin
				o = rsdf_pkg::OP_RECORD;
				s = $urandom();
			end else if (pick < 96) begin
				o = rsdf_pkg::OP_W'($urandom_range(0, 3));
				s = $urandom();
			end else begin
				// restart in the middle, at or behind the head
				o = rsdf_pkg::OP_RESTART;
				s = head - $urandom_range(0, 40);
				head = s;
			end
			send_request(o, s);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = rsdf_pkg::OP_CHECK;
		seq = '0;
		calm = 1'b0;
		squeeze_now = 1'b0;
		sent = 0;
		head = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fresh state: zero and all ones
		send_request(rsdf_pkg::OP_CHECK, 32'd0);
		send_request(rsdf_pkg::OP_CHECK, rsdf_pkg::SEQ_ONES);
		send_request(OP_SPARE, 32'h1234_5678);
		send_request(rsdf_pkg::OP_RECORD, 32'd0);
		send_request(rsdf_pkg::OP_CHECK, 32'd0);
		send_request(rsdf_pkg::OP_RECORD, rsdf_pkg::SEQ_ONES);
		send_request(rsdf_pkg::OP_CHECK, rsdf_pkg::SEQ_ONES);
		send_request(rsdf_pkg::OP_CHECK, 32'd7);
		// restart leaves the low bound at zero, so an older number still records
		send_request(rsdf_pkg::OP_RESTART, 32'd1000);
		send_request(rsdf_pkg::OP_CHECK, 32'd1000);
		send_request(rsdf_pkg::OP_RECORD, 32'd999);
		send_request(rsdf_pkg::OP_RECORD, 32'd998);
		send_request(rsdf_pkg::OP_RECORD, 32'd1000);
		send_request(OP_SPARE, 32'd1001);
		for (int k = 1; k <= 6; k++)
			send_request(rsdf_pkg::OP_RECORD, 32'd1000 + k);
		send_request(rsdf_pkg::OP_CHECK, 32'd999);
		send_request(rsdf_pkg::OP_RESTART, rsdf_pkg::SEQ_ONES);
		send_request(rsdf_pkg::OP_CHECK, rsdf_pkg::SEQ_ONES);
		send_request(rsdf_pkg::OP_RECORD, 32'd0);
		send_request(rsdf_pkg::OP_CHECK, 32'hAAAA_5555);

		squeeze_now = 1'b1;
		while (sent < ITEM_TARGET)
			run_stream();
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4 * RING_DEPTH) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// result side: random stalls, and once a long hold-off to back up requests
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (squeeze_now) begin
				squeeze_now = 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				stall = pick_gap();
				out_ready <= (stall == 0);
				repeat (stall == 0 ? $urandom_range(1, 6) : stall) @(posedge clk);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
hdl/rsdf_pkg.sv
hdl/rsdf_dpath.sv
hdl/rsdf_ctrl.sv
hdl/recent_sequence_duplicate_filter.sv
dv/recent_sequence_duplicate_filter_checker.sv
dv/recent_sequence_duplicate_filter_tb.sv
